@@ rtl/pftc_pkg.sv @@
// Package for the priority flow table classifier.
// Holds the request and result structs, command and action codes, and the entry type.
// Has no dependencies.
package pftc_pkg;

  localparam logic [1:0] CMD_LOOKUP  = 2'd0;
  localparam logic [1:0] CMD_INSTALL = 2'd1;
  localparam logic [1:0] CMD_REMOVE  = 2'd2;

  localparam logic [1:0] ACT_FORWARD    = 2'd0;
  localparam logic [1:0] ACT_DROP       = 2'd1;
  localparam logic [1:0] ACT_CONTROLLER = 2'd2;
  localparam logic [1:0] ACT_MODIFY     = 2'd3;

  localparam logic [1:0] VERDICT_FORWARD    = 2'd0;
  localparam logic [1:0] VERDICT_DROP       = 2'd1;
  localparam logic [1:0] VERDICT_CONTROLLER = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;

  localparam logic [4:0] MASK_SRC_IP   = 5'h01;
  localparam logic [4:0] MASK_DST_IP   = 5'h02;
  localparam logic [4:0] MASK_SRC_PORT = 5'h04;
  localparam logic [4:0] MASK_DST_PORT = 5'h08;
  localparam logic [4:0] MASK_PROTO    = 5'h10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  proto;
    logic [15:0] pkt_length;
    logic [4:0]  field_mask;
    logic [31:0] prio;
    logic [1:0]  act;
    logic [7:0]  egress;
    logic [5:0]  position;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [1:0]  verdict;
    logic [7:0]  out_port;
    logic [31:0] new_dst_ip;
    logic [5:0]  match_position;
    logic [63:0] pkt_total;
    logic [63:0] byte_total;
  } rsp_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  proto;
    logic [4:0]  mask;
    logic [31:0] prio;
    logic [1:0]  act;
    logic [7:0]  port;
    logic [63:0] pkts;
    logic [63:0] bytes;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic        lookup;
    logic        install;
    logic        remove;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  proto;
    logic [15:0] pkt_length;
    logic [4:0]  field_mask;
    logic [31:0] prio;
    logic [1:0]  act;
    logic [7:0]  egress;
  } bcast_t;

endpackage

@@ rtl/pftc_cell.sv @@
// One flow table slot: holds, loads and compares an entry, counts its hits, and shifts with its neighbors.
// Depends on pftc_pkg.
module pftc_cell (
  input  logic              clk,
  input  logic              valid_i,
  input  logic              shift_down_i,
  input  logic              shift_up_i,
  input  logic              load_i,
  input  logic              bump_i,
  input  pftc_pkg::bcast_t  bc_i,
  input  pftc_pkg::entry_t  prev_i,
  input  pftc_pkg::entry_t  next_i,
  output pftc_pkg::entry_t  entry_o,
  output logic              match_o,
  output logic              prio_gt_o
);
  import pftc_pkg::*;

  entry_t e_r;
  entry_t e_nxt;

  always_comb begin
    e_nxt = e_r;
    if (load_i) begin
      e_nxt.src_ip   = bc_i.src_ip;
      e_nxt.dst_ip   = bc_i.dst_ip;
      e_nxt.src_port = bc_i.src_port;
      e_nxt.dst_port = bc_i.dst_port;
      e_nxt.proto    = bc_i.proto;
      e_nxt.mask     = bc_i.field_mask;
      e_nxt.prio     = bc_i.prio;
      e_nxt.act      = bc_i.act;
      e_nxt.port     = bc_i.egress;
      e_nxt.pkts     = 64'd0;
      e_nxt.bytes    = 64'd0;
    end else if (shift_down_i) begin
      e_nxt = prev_i;
    end else if (shift_up_i) begin
      e_nxt = next_i;
    end else if (bump_i) begin
      e_nxt.pkts  = e_r.pkts + 64'd1;
      e_nxt.bytes = e_r.bytes + {48'd0, bc_i.pkt_length};
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

  assign entry_o   = e_r;
  assign prio_gt_o = valid_i && (e_r.prio > bc_i.prio);
  assign match_o   = valid_i
      && (!(|(e_r.mask & MASK_SRC_IP))   || (e_r.src_ip   == bc_i.src_ip))
      && (!(|(e_r.mask & MASK_DST_IP))   || (e_r.dst_ip   == bc_i.dst_ip))
      && (!(|(e_r.mask & MASK_SRC_PORT)) || (e_r.src_port == bc_i.src_port))
      && (!(|(e_r.mask & MASK_DST_PORT)) || (e_r.dst_port == bc_i.dst_port))
      && (!(|(e_r.mask & MASK_PROTO))    || (e_r.proto    == bc_i.proto));

endmodule

@@ rtl/pftc_select.sv @@
// Priority tree, group results registered: finds the first set bit of a vector.
// Depends on pftc_pkg only for house conventions; no other modules.
module pftc_select #(
  parameter int N = 64
) (
  input  logic                 clk,
  input  logic [N-1:0]         vec_i,
  output logic                 any_o,
  output logic [$clog2(N+1)-1:0] idx_o
);
  import pftc_pkg::*;

  localparam int IW = $clog2(N + 1);
  localparam int G  = 8;
  localparam int NG = (N + G - 1) / G;

  logic [NG-1:0]  gany_r;
  logic [IW-1:0]  gidx_r [NG];

  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic          a;
    logic [IW-1:0] ix;
    always_comb begin
      a  = 1'b0;
      ix = '0;
      for (int k = G - 1; k >= 0; k--) begin
        if ((g * G + k < N) && vec_i[(g * G + k) % N]) begin
          a  = 1'b1;
          ix = IW'(g * G + k);
        end
      end
    end
    always_ff @(posedge clk) begin
      gany_r[g] <= a;
      gidx_r[g] <= ix;
    end
  end

  always_comb begin
    any_o = 1'b0;
    idx_o = IW'(N);
    for (int g = NG - 1; g >= 0; g--) begin
      if (gany_r[g]) begin
        any_o = 1'b1;
        idx_o = gidx_r[g];
      end
    end
  end

endmodule

@@ rtl/priority_flow_table_classifier_top.sv @@
// Priority-ordered flow table classifier. A request is taken only when the block is idle; it
// passes through the compare, priority tree and update states before its result is registered,
// so no new request is taken until the last one is done. The update waits while the previous
// result is still held at the output. The row of table cells compares every entry in
// parallel and shifts neighbors for install and remove; the first-hit search is a two-level
// registered tree. Depends on pftc_pkg, pftc_cell and pftc_select.
module priority_flow_table_classifier_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pftc_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pftc_pkg::rsp_t out_data
);
  import pftc_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RW = (IW > 6) ? IW : 6;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [IW-1:0] count_r, count_nxt;
  req_t        req_r;
  logic        out_valid_r, out_valid_nxt;
  rsp_t        rsp_r, rsp_nxt;

  bcast_t      bc;
  entry_t      ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_v, match_v, gt_v, notgt_v, sdn, sup, ld, bmp;
  logic [TABLE_DEPTH-1:0] sel_vec;
  logic        sel_any;
  logic [IW-1:0] sel_idx;
  logic [RW-1:0] rm_pos;
  logic        upd;
  entry_t      hit_e;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    bc.lookup     = req_r.cmd == CMD_LOOKUP;
    bc.install    = req_r.cmd == CMD_INSTALL;
    bc.remove     = req_r.cmd == CMD_REMOVE;
    bc.src_ip     = req_r.src_ip;
    bc.dst_ip     = req_r.dst_ip;
    bc.src_port   = req_r.src_port;
    bc.dst_port   = req_r.dst_port;
    bc.proto      = req_r.proto;
    bc.pkt_length = req_r.pkt_length;
    bc.field_mask = req_r.field_mask;
    bc.prio       = req_r.prio;
    bc.act        = req_r.act;
    bc.egress     = req_r.egress;
  end

  assign rm_pos = RW'(req_r.position);
  assign upd    = (state_r == S_UPD) && (!out_valid_r || out_ready);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign valid_v[i] = IW'(i) < count_r;
    assign notgt_v[i] = !gt_v[i];
    assign ld[i]  = upd && bc.install && (count_r < IW'(TABLE_DEPTH)) && (sel_idx == IW'(i));
    assign sdn[i] = upd && bc.install && (count_r < IW'(TABLE_DEPTH))
                    && (IW'(i) > sel_idx) && (IW'(i) <= count_r);
    assign sup[i] = upd && bc.remove && (rm_pos < RW'(count_r))
                    && (RW'(i) >= rm_pos) && (IW'(i) + IW'(1) < count_r);
    assign bmp[i] = upd && bc.lookup && sel_any && (sel_idx == IW'(i));
    pftc_cell u_cell (
      .clk         (clk),
      .valid_i     (valid_v[i]),
      .shift_down_i(sdn[i]),
      .shift_up_i  (sup[i]),
      .load_i      (ld[i]),
      .bump_i      (bmp[i]),
      .bc_i        (bc),
      .prev_i      (ent[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
      .next_i      (ent[(i + 1) % TABLE_DEPTH]),
      .entry_o     (ent[i]),
      .match_o     (match_v[i]),
      .prio_gt_o   (gt_v[i])
    );
  end

  assign sel_vec = bc.lookup ? match_v : notgt_v;

  pftc_select #(.N(TABLE_DEPTH)) u_sel (
    .clk  (clk),
    .vec_i(sel_vec),
    .any_o(sel_any),
    .idx_o(sel_idx)
  );

  assign hit_e = ent[sel_idx[PW-1:0]];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rsp_nxt       = rsp_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_SEL;
      end
      S_SEL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          rsp_nxt       = '0;
          if (bc.lookup) begin
            rsp_nxt.new_dst_ip = req_r.dst_ip;
            if (sel_any) begin
              rsp_nxt.hit            = 1'b1;
              rsp_nxt.match_position = 6'(sel_idx);
              rsp_nxt.pkt_total      = hit_e.pkts + 64'd1;
              rsp_nxt.byte_total     = hit_e.bytes + {48'd0, req_r.pkt_length};
              case (hit_e.act)
                ACT_FORWARD: begin
                  rsp_nxt.verdict  = VERDICT_FORWARD;
                  rsp_nxt.out_port = hit_e.port;
                end
                ACT_DROP: begin
                  rsp_nxt.verdict = VERDICT_DROP;
                end
                ACT_CONTROLLER: begin
                  rsp_nxt.verdict = VERDICT_CONTROLLER;
                end
                default: begin
                  rsp_nxt.verdict    = VERDICT_FORWARD;
                  rsp_nxt.out_port   = hit_e.port;
                  rsp_nxt.new_dst_ip = hit_e.dst_ip;
                end
              endcase
            end else begin
              rsp_nxt.verdict = VERDICT_CONTROLLER;
            end
          end else if (bc.install) begin
            if (count_r >= IW'(TABLE_DEPTH)) begin
              rsp_nxt.status = ST_FULL;
            end else begin
              rsp_nxt.match_position = 6'(sel_idx < count_r ? sel_idx : count_r);
              count_nxt = count_r + IW'(1);
            end
          end else if (bc.remove) begin
            if (rm_pos >= RW'(count_r)) begin
              rsp_nxt.status = ST_BADPOS;
            end else begin
              count_nxt = count_r - IW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rsp_r <= rsp_nxt;
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = rsp_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IW'(TABLE_DEPTH)) else $error("entry count beyond table depth");
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_result_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> out_valid) else $error("no result after update");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_UPD) |=> $stable(count_r)) else $error("count changed outside update");

endmodule
